>>> rtl/tcw_pkg.sv
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int NCELLS = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(NCELLS);

  localparam int OP_W = 2;
  localparam int CHAR_W = 8;
  localparam int ROW_W = 5;
  localparam int COL_W = 7;

  localparam logic [CHAR_W-1:0] BLANK_ATTR = 8'h07;
  localparam int TAB_STEP = 8;

  localparam logic [CHAR_W-1:0] CH_BS = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR = 8'd13;

  localparam logic [OP_W-1:0] OP_PUT = 2'd0;
  localparam logic [OP_W-1:0] OP_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_SET = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] CUR_HOLD = 2'd0;
  localparam logic [1:0] CUR_PUT = 2'd1;
  localparam logic [1:0] CUR_SET = 2'd2;
  localparam logic [1:0] CUR_HOME = 2'd3;

  localparam logic [2:0] WR_NONE = 3'd0;
  localparam logic [2:0] WR_PUT = 3'd1;
  localparam logic [2:0] WR_COPY = 3'd2;
  localparam logic [2:0] WR_BLANK = 3'd3;
  localparam logic [2:0] WR_ZERO = 3'd4;

  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_CELL = 2'd1;
  localparam logic [1:0] RD_COPY = 2'd2;

  localparam logic [1:0] PTR_HOLD = 2'd0;
  localparam logic [1:0] PTR_CLR = 2'd1;
  localparam logic [1:0] PTR_INC = 2'd2;

  typedef struct packed {
    logic       item_load;
    logic [1:0] cur_cmd;
    logic [2:0] wr_cmd;
    logic [1:0] rd_cmd;
    logic [1:0] ptr_cmd;
    logic       out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            need_scroll;
    logic            copy_end;
    logic            sweep_end;
  } tcw_stat_t;

endpackage

>>> rtl/tcw_datapath.sv
module tcw_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  tcw_pkg::tcw_cmd_t            cmd,
  output tcw_pkg::tcw_stat_t           stat,
  input  logic [tcw_pkg::OP_W-1:0]     opcode,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
  input  logic [tcw_pkg::ROW_W-1:0]    cell_row,
  input  logic [tcw_pkg::COL_W-1:0]    cell_col,
  output logic [tcw_pkg::COL_W-1:0]    cursor_col_out,
  output logic [tcw_pkg::ROW_W-1:0]    cursor_row_out,
  output logic [tcw_pkg::CHAR_W-1:0]   cell_char,
  output logic [tcw_pkg::CHAR_W-1:0]   cell_attr
);
  import tcw_pkg::*;

  logic [CHAR_W-1:0] char_mem [NCELLS];
  logic [CHAR_W-1:0] attr_mem [NCELLS];

  logic [OP_W-1:0]   op_q;
  logic [CHAR_W-1:0] ch_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;

  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col_next;
  logic [ROW_W-1:0]  cursor_row_next;

  logic [ADDR_W-1:0] ptr;
  logic [CHAR_W-1:0] rd_char;
  logic [CHAR_W-1:0] rd_attr;

  logic [ADDR_W-1:0] cursor_idx;
  logic [ADDR_W-1:0] cell_idx;
  logic              rd_ok;

  logic [COL_W:0]    col_ext;
  logic [COL_W:0]    col_inc;
  logic [COL_W:0]    col_tab;
  logic              row_last;
  logic              wrap;
  logic [COL_W-1:0]  put_col;

  logic              wr_char_en;
  logic              wr_attr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CHAR_W-1:0] wr_char;
  logic [CHAR_W-1:0] wr_attr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  assign cursor_idx = ADDR_W'(cursor_row) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_col);
  assign cell_idx = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
  assign rd_ok = (row_q < ROW_W'(ROWS)) && (col_q < COL_W'(COLUMNS));

  assign col_ext = {1'b0, cursor_col};
  assign col_inc = col_ext + (COL_W+1)'(1);
  assign col_tab = (col_ext & ~(COL_W+1)'(TAB_STEP - 1)) + (COL_W+1)'(TAB_STEP);
  assign row_last = (cursor_row == ROW_W'(ROWS - 1));

  always_comb begin
    wrap = 1'b0;
    put_col = cursor_col;
    if (ch_q == CH_LF) begin
      wrap = 1'b1;
    end else if (ch_q == CH_BS) begin
      if (cursor_col != '0) begin
        put_col = cursor_col - COL_W'(1);
      end
    end else if (ch_q == CH_TAB) begin
      if (col_tab >= (COL_W+1)'(COLUMNS)) begin
        wrap = 1'b1;
      end else begin
        put_col = col_tab[COL_W-1:0];
      end
    end else if (ch_q == CH_CR) begin
      put_col = '0;
    end else begin
      if (col_inc >= (COL_W+1)'(COLUMNS)) begin
        wrap = 1'b1;
      end else begin
        put_col = col_inc[COL_W-1:0];
      end
    end
  end

  always_comb begin
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    case (cmd.cur_cmd)
      CUR_PUT: begin
        if (wrap) begin
          cursor_col_next = '0;
          cursor_row_next = row_last ? cursor_row : cursor_row + ROW_W'(1);
        end else begin
          cursor_col_next = put_col;
        end
      end
      CUR_SET: begin
        cursor_col_next = (col_q < COL_W'(COLUMNS)) ? col_q : COL_W'(COLUMNS - 1);
        cursor_row_next = (row_q < ROW_W'(ROWS)) ? row_q : ROW_W'(ROWS - 1);
      end
      CUR_HOME: begin
        cursor_col_next = '0;
        cursor_row_next = '0;
      end
      default: begin
        cursor_col_next = cursor_col;
        cursor_row_next = cursor_row;
      end
    endcase
  end

  always_comb begin
    wr_char_en = 1'b0;
    wr_attr_en = 1'b0;
    wr_addr = ptr;
    wr_char = '0;
    wr_attr = '0;
    case (cmd.wr_cmd)
      WR_PUT: begin
        wr_addr = cursor_idx;
        if (ch_q == CH_BS) begin
          wr_attr_en = (cursor_col != '0);
        end else if (ch_q != CH_LF && ch_q != CH_TAB && ch_q != CH_CR) begin
          wr_char_en = 1'b1;
          wr_attr_en = 1'b1;
          wr_char = ch_q;
          wr_attr = BLANK_ATTR;
        end
      end
      WR_COPY: begin
        wr_addr = ptr - ADDR_W'(1);
        wr_char_en = (ptr != '0);
        wr_attr_en = (ptr != '0);
        wr_char = rd_char;
        wr_attr = rd_attr;
      end
      WR_BLANK: begin
        wr_char_en = 1'b1;
        wr_attr_en = 1'b1;
        wr_attr = BLANK_ATTR;
      end
      WR_ZERO: begin
        wr_char_en = 1'b1;
        wr_attr_en = 1'b1;
      end
      default: begin
        wr_char_en = 1'b0;
        wr_attr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    rd_en = 1'b0;
    rd_addr = cell_idx;
    case (cmd.rd_cmd)
      RD_CELL: begin
        rd_en = rd_ok;
      end
      RD_COPY: begin
        rd_addr = ptr + ADDR_W'(COLUMNS);
        rd_en = (ptr != ADDR_W'(NCELLS - COLUMNS));
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_char_en) begin
      char_mem[wr_addr] <= wr_char;
    end
    if (wr_attr_en) begin
      attr_mem[wr_addr] <= wr_attr;
    end
    if (rd_en) begin
      rd_char <= char_mem[rd_addr];
      rd_attr <= attr_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      ptr <= '0;
    end else begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
      case (cmd.ptr_cmd)
        PTR_CLR: ptr <= '0;
        PTR_INC: ptr <= ptr + ADDR_W'(1);
        default: ptr <= ptr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      op_q <= opcode;
      ch_q <= char_code;
      row_q <= cell_row;
      col_q <= cell_col;
    end
    if (cmd.out_load) begin
      cursor_col_out <= cursor_col_next;
      cursor_row_out <= cursor_row_next;
      if (op_q == OP_READ && rd_ok) begin
        cell_char <= rd_char;
        cell_attr <= rd_attr;
      end else begin
        cell_char <= '0;
        cell_attr <= '0;
      end
    end
  end

  assign stat.op = op_q;
  assign stat.need_scroll = wrap && row_last;
  assign stat.copy_end = (ptr == ADDR_W'(NCELLS - COLUMNS));
  assign stat.sweep_end = (ptr == ADDR_W'(NCELLS - 1));

endmodule

>>> rtl/tcw_ctrl.sv
module tcw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tcw_pkg::tcw_stat_t  stat,
  output tcw_pkg::tcw_cmd_t   cmd
);
  import tcw_pkg::*;

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_RDWAIT = 3'd3;
  localparam logic [2:0] ST_SCROLL = 3'd4;
  localparam logic [2:0] ST_BLANK = 3'd5;
  localparam logic [2:0] ST_CLEAR = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '{item_load: 1'b0, cur_cmd: CUR_HOLD, wr_cmd: WR_NONE, rd_cmd: RD_NONE,
            ptr_cmd: PTR_HOLD, out_load: 1'b0};
    case (state)
      ST_INIT: begin
        cmd.wr_cmd = WR_ZERO;
        if (stat.sweep_end) begin
          state_next = ST_IDLE;
        end else begin
          cmd.ptr_cmd = PTR_INC;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat.op)
          OP_PUT: begin
            cmd.wr_cmd = WR_PUT;
            cmd.cur_cmd = CUR_PUT;
            if (stat.need_scroll) begin
              cmd.ptr_cmd = PTR_CLR;
              state_next = ST_SCROLL;
            end else if (out_free) begin
              cmd.out_load = 1'b1;
              state_next = ST_IDLE;
            end else begin
              state_next = ST_EMIT;
            end
          end
          OP_READ: begin
            cmd.rd_cmd = RD_CELL;
            state_next = ST_RDWAIT;
          end
          OP_SET: begin
            cmd.cur_cmd = CUR_SET;
            if (out_free) begin
              cmd.out_load = 1'b1;
              state_next = ST_IDLE;
            end else begin
              state_next = ST_EMIT;
            end
          end
          default: begin
            cmd.cur_cmd = CUR_HOME;
            cmd.ptr_cmd = PTR_CLR;
            state_next = ST_CLEAR;
          end
        endcase
      end
      ST_SCROLL: begin
        cmd.wr_cmd = WR_COPY;
        cmd.rd_cmd = RD_COPY;
        if (stat.copy_end) begin
          state_next = ST_BLANK;
        end else begin
          cmd.ptr_cmd = PTR_INC;
        end
      end
      ST_BLANK, ST_CLEAR: begin
        cmd.wr_cmd = (state == ST_BLANK) ? WR_BLANK : WR_ZERO;
        if (!stat.sweep_end) begin
          cmd.ptr_cmd = PTR_INC;
        end else if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_RDWAIT, ST_EMIT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_EMIT;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/text_console_writer_core.sv
// Channel  Handshake              Word
// input    in_valid / in_ready    opcode, char_code, cell_row, cell_col
// output   out_valid / out_ready  cursor_col_out, cursor_row_out, cell_char, cell_attr
//
// Read cell, unlike put character and set cursor, passes through a wait state for
// the registered read of the cell store.
// A put character that scrolls copies rows up through the single write port and
// then blanks the bottom row. Clear zeroes the whole store.
// After reset a sweep zeroes the store before the first word is taken.
// A result waits in the output register while out_ready is low. The block still
// takes the next word and works on it, then holds that word's result and any
// further word off until the waiting result is taken.
module text_console_writer_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tcw_pkg::OP_W-1:0]     opcode,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
  input  logic [tcw_pkg::ROW_W-1:0]    cell_row,
  input  logic [tcw_pkg::COL_W-1:0]    cell_col,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tcw_pkg::COL_W-1:0]    cursor_col_out,
  output logic [tcw_pkg::ROW_W-1:0]    cursor_row_out,
  output logic [tcw_pkg::CHAR_W-1:0]   cell_char,
  output logic [tcw_pkg::CHAR_W-1:0]   cell_attr
);
  import tcw_pkg::*;

  tcw_cmd_t  cmd;
  tcw_stat_t stat;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tcw_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .opcode         (opcode),
    .char_code      (char_code),
    .cell_row       (cell_row),
    .cell_col       (cell_col),
    .cursor_col_out (cursor_col_out),
    .cursor_row_out (cursor_row_out),
    .cell_char      (cell_char),
    .cell_attr      (cell_attr)
  );

endmodule

>>> test/tb_text_console_writer_core.sv
module tb_text_console_writer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int N_RANDOM = 1950;
  localparam int HEAVY_MAX = 140;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] attr;
  } console_result_t;

  class console_tracker;
    logic [15:0] screen [NCELLS];
    int cur_col;
    int cur_row;
    console_result_t awaited_results [$];
    int errors;
    int checked;
    int scrolls;
    int clears;
    int reads;

    function new();
      foreach (screen[i]) screen[i] = '0;
      cur_col = 0;
      cur_row = 0;
      errors = 0;
      checked = 0;
      scrolls = 0;
      clears = 0;
      reads = 0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void scroll_up();
      for (int i = 0; i < NCELLS; i++) begin
        screen[i] = (i + COLUMNS < NCELLS) ? screen[i + COLUMNS] : {BLANK_ATTR, 8'h00};
      end
      cur_row = ROWS - 1;
      scrolls++;
    endfunction

    function bit put_is_heavy(logic [CHAR_W-1:0] ch);
      if (ch == CH_LF) return cur_row == ROWS - 1;
      if (ch == CH_TAB) begin
        return cur_row == ROWS - 1 && cur_col + TAB_STEP - cur_col % TAB_STEP >= COLUMNS;
      end
      if (ch == CH_BS || ch == CH_CR) return 1'b0;
      return cur_row == ROWS - 1 && cur_col == COLUMNS - 1;
    endfunction

    function void put_char(logic [CHAR_W-1:0] ch);
      int idx;
      idx = cur_row * COLUMNS + cur_col;
      if (ch == CH_LF) begin
        cur_col = 0;
        cur_row++;
      end else if (ch == CH_BS) begin
        if (cur_col != 0) begin
          screen[idx][15:8] = 8'h00;
          cur_col--;
        end
      end else if (ch == CH_TAB) begin
        cur_col = cur_col + TAB_STEP - cur_col % TAB_STEP;
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
      end else if (ch == CH_CR) begin
        cur_col = 0;
      end else begin
        screen[idx] = {BLANK_ATTR, ch};
        cur_col++;
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
      end
      if (cur_row > ROWS - 1) scroll_up();
    endfunction

    function void note_input(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                             logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
      console_result_t r;
      r = '0;
      case (op)
        OP_PUT: put_char(ch);
        OP_READ: begin
          reads++;
          if (int'(row) < ROWS && int'(col) < COLUMNS) begin
            r.ch = screen[int'(row) * COLUMNS + int'(col)][7:0];
            r.attr = screen[int'(row) * COLUMNS + int'(col)][15:8];
          end
        end
        OP_SET: begin
          cur_col = (int'(col) < COLUMNS) ? int'(col) : COLUMNS - 1;
          cur_row = (int'(row) < ROWS) ? int'(row) : ROWS - 1;
        end
        OP_CLEAR: begin
          foreach (screen[i]) screen[i] = '0;
          cur_col = 0;
          cur_row = 0;
          clears++;
        end
      endcase
      r.col = COL_W'(cur_col);
      r.row = ROW_W'(cur_row);
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                               logic [CHAR_W-1:0] ch, logic [CHAR_W-1:0] attr);
      console_result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual col %0d row %0d char %0d attr %0d",
                 $time, col, row, ch, attr);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      checked++;
      compare_field("cursor_col_out", 8'(want.col), 8'(col));
      compare_field("cursor_row_out", 8'(want.row), 8'(row));
      compare_field("cell_char", want.ch, ch);
      compare_field("cell_attr", want.attr, attr);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [OP_W-1:0] opcode;
  logic [CHAR_W-1:0] char_code;
  logic [ROW_W-1:0] cell_row;
  logic [COL_W-1:0] cell_col;
  logic out_valid;
  logic out_ready;
  logic [COL_W-1:0] cursor_col_out;
  logic [ROW_W-1:0] cursor_row_out;
  logic [CHAR_W-1:0] cell_char;
  logic [CHAR_W-1:0] cell_attr;

  int send_idle;
  int recv_idle;
  int sent = 0;
  int stall_cycles = 0;
  console_tracker sb;

  text_console_writer_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .char_code      (char_code),
    .cell_row       (cell_row),
    .cell_col       (cell_col),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cursor_col_out (cursor_col_out),
    .cursor_row_out (cursor_row_out),
    .cell_char      (cell_char),
    .cell_attr      (cell_attr)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(cursor_col_out, cursor_row_out, cell_char, cell_attr);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_word(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                           logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    char_code <= ch;
    cell_row <= row;
    cell_col <= col;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, ch, row, col);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic put_random();
    int r;
    logic [CHAR_W-1:0] ch;
    r = $urandom_range(0, 99);
    if (r < 8) ch = CH_LF;
    else if (r < 14) ch = CH_CR;
    else if (r < 21) ch = CH_TAB;
    else if (r < 28) ch = CH_BS;
    else ch = CHAR_W'($urandom);
    if (sb.put_is_heavy(ch) && sb.scrolls + sb.clears >= HEAVY_MAX) begin
      send_word(OP_SET, ch, ROW_W'($urandom_range(0, ROWS - 2)),
                COL_W'($urandom_range(0, COLUMNS - 1)));
    end else begin
      send_word(OP_PUT, ch, ROW_W'($urandom), COL_W'($urandom));
    end
  endtask

  task automatic read_near();
    int r;
    r = sb.cur_row - int'($urandom_range(0, 1));
    if (r < 0) r = 0;
    send_word(OP_READ, CHAR_W'($urandom), ROW_W'(r), COL_W'($urandom_range(0, COLUMNS - 1)));
  endtask

  task automatic type_burst();
    send_word(OP_SET, CHAR_W'($urandom), ROW_W'($urandom_range(0, ROWS - 1)),
              COL_W'($urandom_range(0, COLUMNS - 1)));
    repeat ($urandom_range(1, 24)) put_random();
    repeat ($urandom_range(1, 4)) read_near();
  endtask

  task automatic noise_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      put_random();
    end else if (r < 65) begin
      send_word(OP_READ, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
    end else if (r < 90) begin
      send_word(OP_SET, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
    end else if (sb.scrolls + sb.clears < HEAVY_MAX) begin
      send_word(OP_CLEAR, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
    end else begin
      send_word(OP_READ, CHAR_W'($urandom), ROW_W'($urandom_range(0, ROWS - 1)),
                COL_W'($urandom_range(0, COLUMNS - 1)));
    end
  endtask

  initial begin
    int random_start;
    int ph;
    int cur_phase;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_PUT;
    char_code = '0;
    cell_row = '0;
    cell_col = '0;
    out_ready = 1'b0;
    send_idle = 37;
    recv_idle = 54;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_word(OP_READ, 8'h00, 5'd0, 7'd0);
    send_word(OP_PUT, 8'h41, 5'd0, 7'd0);
    send_word(OP_PUT, 8'hFF, 5'd0, 7'd0);
    send_word(OP_PUT, 8'h00, 5'd0, 7'd0);
    send_word(OP_READ, 8'h00, 5'd0, 7'd0);
    send_word(OP_PUT, CH_TAB, 5'd0, 7'd0);
    send_word(OP_PUT, CH_BS, 5'd0, 7'd0);
    send_word(OP_PUT, CH_CR, 5'd0, 7'd0);
    send_word(OP_PUT, CH_BS, 5'd0, 7'd0);
    send_word(OP_SET, 8'h00, 5'd0, 7'd1);
    send_word(OP_PUT, CH_BS, 5'd0, 7'd0);
    send_word(OP_READ, 8'h00, 5'd0, 7'd1);
    send_word(OP_SET, 8'hFF, 5'd31, 7'd127);
    send_word(OP_PUT, 8'h5A, 5'd0, 7'd0);
    send_word(OP_READ, 8'h00, 5'd23, 7'd79);
    send_word(OP_READ, 8'h00, 5'd24, 7'd0);
    send_word(OP_SET, 8'h00, 5'd24, 7'd75);
    send_word(OP_PUT, CH_TAB, 5'd0, 7'd0);
    send_word(OP_SET, 8'h00, 5'd10, 7'd72);
    send_word(OP_PUT, CH_TAB, 5'd0, 7'd0);
    send_word(OP_SET, 8'h00, 5'd24, 7'd5);
    send_word(OP_PUT, CH_LF, 5'd0, 7'd0);
    send_word(OP_READ, 8'h00, 5'd25, 7'd0);
    send_word(OP_READ, 8'h00, 5'd0, 7'd80);
    send_word(OP_CLEAR, 8'h00, 5'd0, 7'd0);
    send_word(OP_READ, 8'h00, 5'd24, 7'd79);

    random_start = sent;
    cur_phase = 0;
    while (sent - random_start < N_RANDOM) begin
      ph = (sent - random_start) * 3 / N_RANDOM;
      if (ph != cur_phase) begin
        cur_phase = ph;
        drain();
        send_idle = (ph == 1) ? 54 : 0;
        recv_idle = (ph == 1) ? 37 : 0;
      end
      if ($urandom_range(0, 99) < 70) type_burst();
      else noise_word();
    end

    drain();
    repeat (10) @(posedge clk);

    $display("Sent %0d words: %0d cell reads, %0d scrolls, %0d clears.",
             sent, sb.reads, sb.scrolls, sb.clears);
    $display("Checked %0d results across three idle patterns, %0d mismatches.",
             sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
